// ===== rtl/core/calendar_date_add_subtract_core_defines.svh =====
// Assertion macros shared by the calendar date core.
`ifndef CALENDAR_DATE_ADD_SUBTRACT_CORE_DEFINES_SVH
`define CALENDAR_DATE_ADD_SUBTRACT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on clk, off while arst_n is low.
`define CDAS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("calendar date core: assertion failed");
// Next-cycle implication, checked on clk, off while arst_n is low.
`define CDAS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("calendar date core: assertion failed");
`else
`define CDAS_ASSERT_IMP(lbl, ante, cons)
`define CDAS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/cdas_pkg.sv =====
// Types, constants and calendar helpers for the calendar date core.
`default_nettype none
package cdas_pkg;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_ADD  = 2'd1;
	localparam logic [1:0] OP_SUB  = 2'd2;

	localparam logic [13:0] YEAR_MAX   = 14'd16383;
	localparam logic [13:0] YEAR_RESET = 14'd2000;
	localparam logic [6:0]  YEAR_RESET_CENT = 7'd20;

	localparam logic [4:0] HOURS_PER_DAY = 5'd24;
	localparam logic [4:0] HOUR_MAX      = 5'd23;
	localparam logic [5:0] MINUTE_MAX    = 6'd59;
	localparam logic [3:0] MONTHS        = 4'd12;
	localparam logic [3:0] MONTH_FEB     = 4'd2;
	localparam logic [4:0] FEB_LEAP_LEN  = 5'd29;

	// floor(y / 100) = (y * 5243) >> 19 for any 14-bit year
	localparam logic [12:0] RECIP_100 = 13'd5243;
	// floor(x / 3) = (x * 171) >> 9 for x below 512
	localparam logic [7:0]  RECIP_3   = 8'd171;

	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_REM,
		ST_HOUR,
		ST_STEP,
		ST_FINISH
	} cdas_state_t;

	typedef struct packed {
		logic capture;
		logic load;
		logic div;
		logic rem;
		logic hour;
		logic step;
		logic publish;
	} cdas_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic leap_ok;
	} cdas_status_t;

	function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
		logic [3:0] idx;
		idx = month - 4'd1;
		if (month == MONTH_FEB && leap) begin
			return FEB_LEAP_LEN;
		end else if (idx < MONTHS) begin
			return MONTH_LEN[idx];
		end else begin
			return MONTH_LEN[0];
		end
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cdas_if.sv =====
// Request and response channel interfaces of the calendar date core.
`default_nettype none
interface cdas_req_if #(
	parameter int DAY_COUNT_BITS = 16
);
	logic                      valid;
	logic                      ready;
	logic [1:0]                op;
	logic [4:0]                load_day;
	logic [3:0]                load_month;
	logic [13:0]               load_year;
	logic [4:0]                load_hour;
	logic [5:0]                load_minute;
	logic [DAY_COUNT_BITS-1:0] day_count;
	logic [9:0]                hour_count;

	modport source (
		output valid, op, load_day, load_month, load_year, load_hour, load_minute,
		output day_count, hour_count,
		input  ready
	);
	modport sink (
		input  valid, op, load_day, load_month, load_year, load_hour, load_minute,
		input  day_count, hour_count,
		output ready
	);
endinterface

interface cdas_rsp_if;
	logic        valid;
	logic        ready;
	logic [4:0]  out_day;
	logic [3:0]  out_month;
	logic [13:0] out_year;
	logic [4:0]  out_hour;
	logic [5:0]  out_minute;
	logic        year_wrapped;

	modport source (
		output valid, out_day, out_month, out_year, out_hour, out_minute, year_wrapped,
		input  ready
	);
	modport sink (
		input  valid, out_day, out_month, out_year, out_hour, out_minute, year_wrapped,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/core/cdas_ctrl.sv =====
// Sequencer of the calendar date core: request intake, step loop, result handoff.
`default_nettype none
module cdas_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            in_op,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  cdas_pkg::cdas_status_t status,
	output cdas_pkg::cdas_cmd_t    cmd
);

	cdas_pkg::cdas_state_t state_q, state_d;
	logic                  out_valid_q;
	logic                  slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			cdas_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (in_op)
						cdas_pkg::OP_LOAD: state_d = cdas_pkg::ST_LOAD;
						cdas_pkg::OP_ADD:  state_d = cdas_pkg::ST_DIV;
						cdas_pkg::OP_SUB:  state_d = cdas_pkg::ST_DIV;
						default:           state_d = cdas_pkg::ST_FINISH;
					endcase
				end
			end
			cdas_pkg::ST_LOAD: state_d = cdas_pkg::ST_FINISH;
			cdas_pkg::ST_DIV:  state_d = cdas_pkg::ST_REM;
			cdas_pkg::ST_REM:  state_d = cdas_pkg::ST_HOUR;
			cdas_pkg::ST_HOUR: state_d = cdas_pkg::ST_STEP;
			cdas_pkg::ST_STEP: begin
				if (status.n_zero) begin
					state_d = cdas_pkg::ST_FINISH;
				end
			end
			cdas_pkg::ST_FINISH: begin
				if (slot_free) begin
					state_d = cdas_pkg::ST_IDLE;
				end
			end
			default: state_d = cdas_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			cdas_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			cdas_pkg::ST_LOAD:   cmd.load = 1'b1;
			cdas_pkg::ST_DIV:    cmd.div  = 1'b1;
			cdas_pkg::ST_REM:    cmd.rem  = 1'b1;
			cdas_pkg::ST_HOUR:   cmd.hour = 1'b1;
			// hold while the leap flag catches up with a new year
			cdas_pkg::ST_STEP:   cmd.step = !status.n_zero && status.leap_ok;
			cdas_pkg::ST_FINISH: cmd.publish = slot_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cdas_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== rtl/core/cdas_datapath.sv =====
// Date registers, hour split, leap pipeline and month stepper of the calendar date core.
`default_nettype none
module cdas_datapath #(
	parameter int DAY_COUNT_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cdas_pkg::cdas_cmd_t       cmd,
	output cdas_pkg::cdas_status_t    status,
	input  logic [1:0]                in_op,
	input  logic [4:0]                in_load_day,
	input  logic [3:0]                in_load_month,
	input  logic [13:0]               in_load_year,
	input  logic [4:0]                in_load_hour,
	input  logic [5:0]                in_load_minute,
	input  logic [DAY_COUNT_BITS-1:0] in_day_count,
	input  logic [9:0]                in_hour_count,
	output logic [4:0]                out_day,
	output logic [3:0]                out_month,
	output logic [13:0]               out_year,
	output logic [4:0]                out_hour,
	output logic [5:0]                out_minute,
	output logic                      out_year_wrapped
);

	// remaining-day counter: day count plus up to 43 days from the hours
	localparam int NW = ((DAY_COUNT_BITS > 6) ? DAY_COUNT_BITS : 6) + 1;

	// captured request
	logic                      back_q;
	logic [4:0]                ld_day_q;
	logic [3:0]                ld_month_q;
	logic [13:0]               ld_year_q;
	logic [4:0]                ld_hour_q;
	logic [5:0]                ld_minute_q;
	logic [DAY_COUNT_BITS-1:0] dcnt_q;
	logic [9:0]                hrs_q;

	// hour split
	logic [5:0]  hdays_q;
	logic [4:0]  hrem_q;
	logic [14:0] div3_prod;
	logic [9:0]  hdays_x24;

	// held date
	logic [4:0]  day_q;
	logic [3:0]  month_q;
	logic [13:0] year_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic        wrap_q;
	logic [NW-1:0] n_q;

	// leap pipeline
	logic [26:0] cent_prod;
	logic [13:0] year_s1;
	logic [7:0]  cent_s1;
	logic        leap_q;
	logic [13:0] leap_year_q;
	logic [14:0] cent_x100;
	logic        cent_zero;
	logic        leap_d;

	// hour adjust
	logic [5:0] fwd_sum;
	logic       fwd_carry;
	logic [4:0] fwd_hour;
	logic       back_borrow;
	logic [4:0] back_hour;
	logic       carry;

	// month stepper
	logic [4:0] len;
	logic [5:0] fwd_k;
	logic       fwd_done;
	logic       back_done;
	logic [3:0] prev_month;
	logic [4:0] prev_len;
	logic       year_up_wrap;
	logic       year_dn_wrap;

	// load saturation
	logic [4:0] sat_day;
	logic [3:0] sat_month;
	logic [4:0] sat_hour;
	logic [5:0] sat_minute;

	function automatic logic [6:0] in_hour_div8(input logic [9:0] h);
		return h[9:3];
	endfunction

	assign div3_prod = 15'(in_hour_div8(hrs_q)) * 15'(cdas_pkg::RECIP_3);
	assign hdays_x24 = {hdays_q, 4'b0} + {1'b0, hdays_q, 3'b0};

	assign cent_prod = 27'(year_q) * 27'(cdas_pkg::RECIP_100);
	assign cent_x100 = 15'({cent_s1, 6'b0}) + 15'({cent_s1, 5'b0}) + 15'({cent_s1, 2'b0});
	assign cent_zero = (cent_x100 == 15'(year_s1));
	assign leap_d    = ((year_s1[1:0] == 2'b00) && !cent_zero)
	                || (cent_zero && (cent_s1[1:0] == 2'b00));

	assign status.leap_ok = (leap_year_q == year_q);
	assign status.n_zero  = (n_q == '0);

	assign fwd_sum     = 6'(hour_q) + 6'(hrem_q);
	assign fwd_carry   = (fwd_sum >= 6'(cdas_pkg::HOURS_PER_DAY));
	assign fwd_hour    = fwd_carry ? 5'(fwd_sum - 6'(cdas_pkg::HOURS_PER_DAY)) : 5'(fwd_sum);
	assign back_borrow = (hour_q < hrem_q);
	assign back_hour   = back_borrow
		? 5'(6'(hour_q) + 6'(cdas_pkg::HOURS_PER_DAY) - 6'(hrem_q))
		: (hour_q - hrem_q);
	assign carry       = back_q ? back_borrow : fwd_carry;

	assign len       = cdas_pkg::days_in_month(month_q, leap_q);
	assign fwd_k     = (day_q < len) ? (6'(len - day_q) + 6'd1) : 6'd1;
	assign fwd_done  = (n_q < NW'(fwd_k));
	assign back_done = (n_q < NW'(day_q));
	assign prev_month = (month_q == 4'd1) ? cdas_pkg::MONTHS : (month_q - 4'd1);
	assign prev_len   = cdas_pkg::days_in_month(prev_month, leap_q);
	assign year_up_wrap = (year_q == cdas_pkg::YEAR_MAX);
	assign year_dn_wrap = (year_q == '0);

	assign sat_day    = (ld_day_q == '0) ? 5'd1 : ld_day_q;
	assign sat_month  = (ld_month_q == '0) ? 4'd1
	                  : ((ld_month_q > cdas_pkg::MONTHS) ? cdas_pkg::MONTHS : ld_month_q);
	assign sat_hour   = (ld_hour_q > cdas_pkg::HOUR_MAX) ? cdas_pkg::HOUR_MAX : ld_hour_q;
	assign sat_minute = (ld_minute_q > cdas_pkg::MINUTE_MAX) ? cdas_pkg::MINUTE_MAX : ld_minute_q;

	// capture, split and result registers carry payload only
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			back_q      <= (in_op == cdas_pkg::OP_SUB);
			ld_day_q    <= in_load_day;
			ld_month_q  <= in_load_month;
			ld_year_q   <= in_load_year;
			ld_hour_q   <= in_load_hour;
			ld_minute_q <= in_load_minute;
			dcnt_q      <= in_day_count;
			hrs_q       <= in_hour_count;
		end
		if (cmd.div) begin
			hdays_q <= div3_prod[14:9];
		end
		if (cmd.rem) begin
			hrem_q <= 5'(hrs_q - hdays_x24);
		end
		if (cmd.publish) begin
			out_day          <= day_q;
			out_month        <= month_q;
			out_year         <= year_q;
			out_hour         <= hour_q;
			out_minute       <= minute_q;
			out_year_wrapped <= wrap_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_s1     <= cdas_pkg::YEAR_RESET;
			cent_s1     <= 8'(cdas_pkg::YEAR_RESET_CENT);
			leap_q      <= 1'b1;
			leap_year_q <= cdas_pkg::YEAR_RESET;
		end else begin
			year_s1     <= year_q;
			cent_s1     <= cent_prod[26:19];
			leap_q      <= leap_d;
			leap_year_q <= year_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q    <= 5'd1;
			month_q  <= 4'd1;
			year_q   <= cdas_pkg::YEAR_RESET;
			hour_q   <= '0;
			minute_q <= '0;
			wrap_q   <= 1'b0;
			n_q      <= '0;
		end else begin
			if (cmd.capture) begin
				wrap_q <= 1'b0;
			end
			if (cmd.load) begin
				day_q    <= sat_day;
				month_q  <= sat_month;
				year_q   <= ld_year_q;
				hour_q   <= sat_hour;
				minute_q <= sat_minute;
			end
			if (cmd.hour) begin
				hour_q <= back_q ? back_hour : fwd_hour;
				n_q    <= NW'(dcnt_q) + NW'(hdays_q) + NW'(carry);
			end
			if (cmd.step) begin
				if (!back_q) begin
					if (fwd_done) begin
						day_q <= day_q + n_q[4:0];
						n_q   <= '0;
					end else begin
						n_q   <= n_q - NW'(fwd_k);
						day_q <= 5'd1;
						if (month_q >= cdas_pkg::MONTHS) begin
							month_q <= 4'd1;
							year_q  <= year_q + 14'd1;
							if (year_up_wrap) begin
								wrap_q <= 1'b1;
							end
						end else begin
							month_q <= month_q + 4'd1;
						end
					end
				end else begin
					if (back_done) begin
						day_q <= day_q - n_q[4:0];
						n_q   <= '0;
					end else begin
						n_q     <= n_q - NW'(day_q);
						month_q <= prev_month;
						day_q   <= prev_len;
						if (month_q == 4'd1) begin
							year_q <= year_q - 14'd1;
							if (year_dn_wrap) begin
								wrap_q <= 1'b1;
							end
						end
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/calendar_date_add_subtract_core.sv =====
// Top level of the calendar date core: sequencer, datapath and channel wiring.
`default_nettype none
`include "calendar_date_add_subtract_core_defines.svh"
// Gregorian date keeper. The block holds day, month, year (0..16383, wrapping), hour and
// minute, reset to 1 Jan 2000 00:00. Each request on req carries an op: load sets the date
// (out-of-range fields saturate), add moves it forward by day_count days plus hour_count
// hours, subtract moves it back; op 3 only reports. Every request yields exactly one result
// on rsp with the date held afterwards and year_wrapped set when the year crossed its range.
// Requests are handled one at a time; req is ready again as soon as the previous one has
// finished, even while its result still sits in the output register. Op 3 goes straight
// to the result; load first writes the saturated fields; add or subtract capture the
// request, split the hours into days and a remainder, adjust the hour, then step the date
// one month boundary at a time, with a closing part-month step. A finished result also
// waits while rsp holds off the one before it. The time an add or subtract takes is set
// by the single month stepper in the datapath, which moves one month per cycle, and by
// the two-stage leap-year pipeline, which the stepper waits for after every change of
// year.
module calendar_date_add_subtract_core #(
	parameter int DAY_COUNT_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	cdas_req_if.sink  req,
	cdas_rsp_if.source rsp
);

	cdas_pkg::cdas_cmd_t    cmd;
	cdas_pkg::cdas_status_t status;

	// sequencer: take a request, drive the datapath, hand the result to rsp
	cdas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.in_op     (req.op),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: date registers, hour split, leap flag, month stepper, result register
	cdas_datapath #(
		.DAY_COUNT_BITS (DAY_COUNT_BITS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.in_op            (req.op),
		.in_load_day      (req.load_day),
		.in_load_month    (req.load_month),
		.in_load_year     (req.load_year),
		.in_load_hour     (req.load_hour),
		.in_load_minute   (req.load_minute),
		.in_day_count     (req.day_count),
		.in_hour_count    (req.hour_count),
		.out_day          (rsp.out_day),
		.out_month        (rsp.out_month),
		.out_year         (rsp.out_year),
		.out_hour         (rsp.out_hour),
		.out_minute       (rsp.out_minute),
		.out_year_wrapped (rsp.year_wrapped)
	);

	// req is not ready in the cycle after a request is taken
	`CDAS_ASSERT_NXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
	// a new result appears only right after the sequencer published it
	`CDAS_ASSERT_IMP(a_result_from_publish, $rose(rsp.valid), $past(cmd.publish))
	// a shown result always carries a month in 1..12 and a nonzero day
	`CDAS_ASSERT_IMP(a_date_legal, rsp.valid, (rsp.out_month - 4'd1) < cdas_pkg::MONTHS && |rsp.out_day)

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the calendar date core: random and directed date requests.
`timescale 1ns / 1ps
module tb;

	// The package names load, add and subtract only; the fourth code just reports.
	localparam logic [1:0] OP_NOP = 2'd3;
	localparam int DCB = 16;
	// Idle odds in percent, for each side.
	localparam int IDLE_PCT = 26;
	// Length of the long result stall that backs the block up into its input.
	localparam int SINK_HOLD = 400;
	// Settle time at the end. Every request returns a result, so the block is quiet by then.
	localparam int SETTLE = 64;
	// Even if every request were the worst add or subtract, with idling and stalls,
	// this limit stays well above the run.
	localparam int unsigned CYCLE_LIMIT = 20_000_000;

	typedef struct packed {
		logic [1:0]     op;
		logic [4:0]     load_day;
		logic [3:0]     load_month;
		logic [13:0]    load_year;
		logic [4:0]     load_hour;
		logic [5:0]     load_minute;
		logic [DCB-1:0] day_count;
		logic [9:0]     hour_count;
	} date_req_t;

	typedef struct packed {
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic        wrapped;
	} date_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Hold every block input at a known value from time zero.
	logic      drv_valid = 1'b0;
	date_req_t drv_req = '0;
	logic      rsp_rdy = 1'b0;

	cdas_req_if #(.DAY_COUNT_BITS(DCB)) req_ch ();
	cdas_rsp_if                         rsp_ch ();

	assign req_ch.valid       = drv_valid;
	assign req_ch.op          = drv_req.op;
	assign req_ch.load_day    = drv_req.load_day;
	assign req_ch.load_month  = drv_req.load_month;
	assign req_ch.load_year   = drv_req.load_year;
	assign req_ch.load_hour   = drv_req.load_hour;
	assign req_ch.load_minute = drv_req.load_minute;
	assign req_ch.day_count   = drv_req.day_count;
	assign req_ch.hour_count  = drv_req.hour_count;
	assign rsp_ch.ready       = rsp_rdy;

	calendar_date_add_subtract_core #(.DAY_COUNT_BITS(DCB)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	always #6 clk = ~clk;

	date_req_t   date_ops_pending[$];
	date_t       expected_dates[$];
	int unsigned mismatches = 0;
	int unsigned results_checked = 0;
	int unsigned wraps_predicted = 0;
	int unsigned op_seen[4] = '{default: 0};
	int unsigned holds_wanted = 0;
	int unsigned holds_done = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;
	logic        no_idle = 1'b0;

	// Date held by the predictor, starting from the reset value of the block.
	logic [4:0]  held_day = 5'd1;
	logic [3:0]  held_month = 4'd1;
	logic [13:0] held_year = cdas_pkg::YEAR_RESET;
	logic [4:0]  held_hour = 5'd0;
	logic [5:0]  held_minute = 6'd0;

	// Gregorian rule, applied to the wrapped 14-bit year, so year 0 is a leap year.
	function automatic logic leap_year(input logic [13:0] y);
		return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
	endfunction

	function automatic logic [4:0] month_length(input logic [3:0] m, input logic [13:0] y);
		if (m == cdas_pkg::MONTH_FEB && leap_year(y)) begin
			return cdas_pkg::FEB_LEAP_LEN;
		end
		return cdas_pkg::MONTH_LEN[m - 4'd1];
	endfunction

	// Apply one request to the held date and return the result it must produce.
	function automatic date_t advance_date(input date_req_t rq);
		int unsigned days;
		int unsigned step;
		int unsigned rem;
		int unsigned hr;
		logic [4:0]  len;
		logic        wrap;
		date_t       res;
		wrap = 1'b0;
		case (rq.op)
		cdas_pkg::OP_LOAD: begin
			// Saturate each field into its range; a day past the month end is kept.
			held_day = (rq.load_day == 5'd0) ? 5'd1 : rq.load_day;
			held_month = (rq.load_month == 4'd0) ? 4'd1 :
				(rq.load_month > cdas_pkg::MONTHS ? cdas_pkg::MONTHS : rq.load_month);
			held_year = rq.load_year;
			held_hour = (rq.load_hour > cdas_pkg::HOUR_MAX) ? cdas_pkg::HOUR_MAX
				: rq.load_hour;
			held_minute = (rq.load_minute > cdas_pkg::MINUTE_MAX) ? cdas_pkg::MINUTE_MAX
				: rq.load_minute;
		end
		cdas_pkg::OP_ADD: begin
			days = rq.day_count + rq.hour_count / cdas_pkg::HOURS_PER_DAY;
			rem = rq.hour_count % cdas_pkg::HOURS_PER_DAY;
			hr = held_hour + rem;
			if (hr >= cdas_pkg::HOURS_PER_DAY) begin
				hr = hr - cdas_pkg::HOURS_PER_DAY;
				days++;
			end
			held_hour = 5'(hr);
			// Step to the first of the next month while the count allows it.
			while (days > 0) begin
				len = month_length(held_month, held_year);
				step = (held_day < len) ? len - held_day + 1 : 1;
				if (days < step) begin
					held_day = held_day + 5'(days);
					days = 0;
				end else begin
					days = days - step;
					held_day = 5'd1;
					if (held_month == cdas_pkg::MONTHS) begin
						held_month = 4'd1;
						if (held_year == cdas_pkg::YEAR_MAX) begin
							held_year = '0;
							wrap = 1'b1;
						end else begin
							held_year++;
						end
					end else begin
						held_month++;
					end
				end
			end
		end
		cdas_pkg::OP_SUB: begin
			days = rq.day_count + rq.hour_count / cdas_pkg::HOURS_PER_DAY;
			rem = rq.hour_count % cdas_pkg::HOURS_PER_DAY;
			if (held_hour < rem) begin
				held_hour = 5'(held_hour + cdas_pkg::HOURS_PER_DAY - rem);
				days++;
			end else begin
				held_hour = 5'(held_hour - rem);
			end
			// Step back to the last day of the previous month, counting from the held day.
			while (days > 0) begin
				if (days < held_day) begin
					held_day = held_day - 5'(days);
					days = 0;
				end else begin
					days = days - held_day;
					if (held_month == 4'd1) begin
						held_month = cdas_pkg::MONTHS;
						if (held_year == '0) begin
							held_year = cdas_pkg::YEAR_MAX;
							wrap = 1'b1;
						end else begin
							held_year--;
						end
					end else begin
						held_month--;
					end
					held_day = month_length(held_month, held_year);
				end
			end
		end
		default: begin
		end
		endcase
		res.day = held_day;
		res.month = held_month;
		res.year = held_year;
		res.hour = held_hour;
		res.minute = held_minute;
		res.wrapped = wrap;
		return res;
	endfunction

	function automatic date_req_t make_req(input logic [1:0] op, input int d, input int m,
			input int y, input int h, input int mi, input int dc, input int hc);
		date_req_t rq;
		rq.op = op;
		rq.load_day = 5'(d);
		rq.load_month = 4'(m);
		rq.load_year = 14'(y);
		rq.load_hour = 5'(h);
		rq.load_minute = 6'(mi);
		rq.day_count = DCB'(dc);
		rq.hour_count = 10'(hc);
		return rq;
	endfunction

	// Queue random requests. Loads favor years near the ends of the range and near
	// century years, so that later offsets wrap and hit the leap exceptions often.
	task automatic queue_random(input int count);
		date_req_t   rq;
		int unsigned pick;
		repeat (count) begin
			rq = date_req_t'({$urandom, $urandom, $urandom});
			pick = $urandom_range(99);
			if (pick < 22) begin
				rq.op = cdas_pkg::OP_LOAD;
			end else if (pick < 58) begin
				rq.op = cdas_pkg::OP_ADD;
			end else if (pick < 94) begin
				rq.op = cdas_pkg::OP_SUB;
			end else begin
				rq.op = OP_NOP;
			end
			if (rq.op == cdas_pkg::OP_LOAD) begin
				if ($urandom_range(99) < 85) begin
					rq.load_day = 5'($urandom_range(31, 1));
					rq.load_month = 4'($urandom_range(12, 1));
					rq.load_hour = 5'($urandom_range(23, 0));
					rq.load_minute = 6'($urandom_range(59, 0));
				end
				case ($urandom_range(4))
				0: rq.load_year = 14'($urandom_range(400, 0));
				1: rq.load_year = 14'($urandom_range(cdas_pkg::YEAR_MAX,
					cdas_pkg::YEAR_MAX - 400));
				2: rq.load_year = 14'($urandom_range(2110, 1890));
				3: rq.load_year = 14'(100 * $urandom_range(163, 0) + $urandom_range(1, 0));
				default: begin
				end
				endcase
			end else if (rq.op != OP_NOP) begin
				pick = $urandom_range(99);
				if (pick < 65) begin
					rq.day_count = DCB'($urandom_range(62, 0));
				end else if (pick < 90) begin
					rq.day_count = DCB'($urandom_range(2000, 0));
				end else if (pick < 96) begin
					rq.day_count = DCB'($urandom_range(65535, 0));
				end else begin
					rq.day_count = DCB'(65535 - $urandom_range(15, 0));
				end
				if ($urandom_range(99) < 30) begin
					rq.hour_count = 10'($urandom_range(47, 0));
				end
			end
			date_ops_pending.push_back(rq);
		end
	endtask

	// Block until the driver is empty and every predicted result has been seen.
	task automatic wait_drained();
		while (date_ops_pending.size() != 0 || expected_dates.size() != 0 || drv_valid) begin
			@(negedge clk);
		end
	endtask

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	// Request driver: predict each accepted request, then offer the next one or idle.
	always @(posedge clk or negedge arst_n) begin : driver
		date_t due;
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else begin
			if (drv_valid && req_ch.ready) begin
				due = advance_date(drv_req);
				expected_dates.push_back(due);
				op_seen[drv_req.op]++;
				if (due.wrapped) begin
					wraps_predicted++;
				end
			end
			// Change the offer only once the current request is gone or none is up.
			if (!drv_valid || req_ch.ready) begin
				if (date_ops_pending.size() != 0 &&
						(no_idle || $urandom_range(99) >= IDLE_PCT)) begin
					drv_req <= date_ops_pending.pop_front();
					drv_valid <= 1'b1;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare against the oldest prediction, then pick next ready.
	always @(posedge clk or negedge arst_n) begin : monitor
		date_t due;
		if (!arst_n) begin
			rsp_rdy <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_rdy) begin
				if (expected_dates.size() == 0) begin
					$error("result with no request outstanding: day %0d month %0d year %0d",
						rsp_ch.out_day, rsp_ch.out_month, rsp_ch.out_year);
					mismatches++;
				end else begin
					due = expected_dates.pop_front();
					check_field("out_day", due.day, rsp_ch.out_day);
					check_field("out_month", due.month, rsp_ch.out_month);
					check_field("out_year", due.year, rsp_ch.out_year);
					check_field("out_hour", due.hour, rsp_ch.out_hour);
					check_field("out_minute", due.minute, rsp_ch.out_minute);
					check_field("year_wrapped", due.wrapped, rsp_ch.year_wrapped);
					results_checked++;
				end
			end
			// A long stall, when asked for, takes priority over random idling.
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_rdy <= 1'b0;
			end else if (holds_wanted > holds_done) begin
				holds_done <= holds_done + 1;
				hold_left <= SINK_HOLD;
				rsp_rdy <= 1'b0;
			end else begin
				rsp_rdy <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Watchdog: give up when the run takes far longer than it ever should.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// Stimulus sequence. All writes here land on the falling edge, clear of the
	// rising edge where the driver and monitor sample.
	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: report on the reset date, zero and largest hour offsets.
		date_ops_pending.push_back(make_req(OP_NOP, 0, 0, 0, 0, 0, 0, 0));
		date_ops_pending.push_back(make_req(cdas_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 0));
		date_ops_pending.push_back(make_req(cdas_pkg::OP_ADD, 0, 0, 0, 0, 0, 0, 1023));
		date_ops_pending.push_back(make_req(cdas_pkg::OP_SUB, 0, 0, 0, 0, 0, 0, 1023));
		// Wrap forward off the last year by a single day.
		date_ops_pending.push_back(make_req(cdas_pkg::OP_LOAD, 31, 12, cdas_pkg::YEAR_MAX,
			23, 59, 0, 0));
		date_ops_pending.push_back(make_req(cdas_pkg::OP_ADD, 0, 0, 0, 0, 0, 1, 0));
		// Wrap back from year zero through an hour borrow alone.
		date_ops_pending.push_back(make_req(cdas_pkg::OP_LOAD, 1, 1, 0, 0, 0, 0, 0));
		date_ops_pending.push_back(make_req(cdas_pkg::OP_SUB, 0, 0, 0, 0, 0, 0, 1));
		// Out-of-range loads saturate: zero day and month with high hour and minute, then high month, hour and minute.
		date_ops_pending.push_back(make_req(cdas_pkg::OP_LOAD, 0, 0, 5461, 31, 63, 0, 0));
		date_ops_pending.push_back(make_req(cdas_pkg::OP_LOAD, 31, 15, 10922, 24, 60, 0, 0));
		// Day past the month end: add jumps to the next month, subtract counts down.
		date_ops_pending.push_back(make_req(cdas_pkg::OP_LOAD, 31, 2, 2001, 12, 30, 0, 0));
		date_ops_pending.push_back(make_req(cdas_pkg::OP_ADD, 0, 0, 0, 0, 0, 1, 0));
		date_ops_pending.push_back(make_req(cdas_pkg::OP_LOAD, 30, 2, 1900, 5, 5, 0, 0));
		date_ops_pending.push_back(make_req(cdas_pkg::OP_SUB, 0, 0, 0, 0, 0, 1, 0));
		// Leap rule: every fourth year, not centuries, except every fourth century.
		date_ops_pending.push_back(make_req(cdas_pkg::OP_LOAD, 28, 2, 2000, 0, 0, 0, 0));
		date_ops_pending.push_back(make_req(cdas_pkg::OP_ADD, 0, 0, 0, 0, 0, 1, 0));
		date_ops_pending.push_back(make_req(cdas_pkg::OP_LOAD, 28, 2, 2100, 0, 0, 0, 0));
		date_ops_pending.push_back(make_req(cdas_pkg::OP_ADD, 0, 0, 0, 0, 0, 2, 0));
		date_ops_pending.push_back(make_req(cdas_pkg::OP_LOAD, 1, 3, 2400, 0, 0, 0, 0));
		date_ops_pending.push_back(make_req(cdas_pkg::OP_SUB, 0, 0, 0, 0, 0, 1, 0));
		// Largest offsets, both directions, each wrapping the year.
		date_ops_pending.push_back(make_req(cdas_pkg::OP_LOAD, 1, 1, 16300, 0, 0, 0, 0));
		date_ops_pending.push_back(make_req(cdas_pkg::OP_ADD, 0, 0, 0, 0, 0, 65535, 1023));
		date_ops_pending.push_back(make_req(cdas_pkg::OP_LOAD, 1, 1, 100, 0, 0, 0, 0));
		date_ops_pending.push_back(make_req(cdas_pkg::OP_SUB, 0, 0, 0, 0, 0, 65535, 1023));
		date_ops_pending.push_back(make_req(OP_NOP, 31, 15, cdas_pkg::YEAR_MAX, 31, 63,
			65535, 1023));
		// Pause the sender until the directed part has fully drained.
		wait_drained();

		// Random with idling on both sides; stall results long enough to back up req.
		holds_wanted = 1;
		queue_random(600);
		wait_drained();

		// Back-to-back stretch with no idling on either side.
		no_idle = 1'b1;
		queue_random(450);
		wait_drained();

		no_idle = 1'b0;
		holds_wanted = 2;
		queue_random(600);
		wait_drained();
		repeat (SETTLE) @(negedge clk);

		$display("summary: %0d loads, %0d adds, %0d subtracts, %0d reports accepted",
			op_seen[cdas_pkg::OP_LOAD], op_seen[cdas_pkg::OP_ADD],
			op_seen[cdas_pkg::OP_SUB], op_seen[OP_NOP]);
		$display("summary: %0d results checked, %0d with a year wrap, %0d long result stalls",
			results_checked, wraps_predicted, holds_done);
		if (mismatches == 0 && expected_dates.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cdas_pkg.sv
rtl/core/cdas_if.sv
rtl/core/cdas_ctrl.sv
rtl/core/cdas_datapath.sv
rtl/core/calendar_date_add_subtract_core.sv
dv/tb.sv
